>>> hdl/quadrature_point_affine_map_top_macros.svh
// assertion macros shared by the affine map block
`ifndef QUADRATURE_POINT_AFFINE_MAP_TOP_MACROS_SVH
`define QUADRATURE_POINT_AFFINE_MAP_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked property, ignored while reset is low
`define QPAM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qpam: assertion failed");

// checked property, evaluated during reset too
`define QPAM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("qpam: assertion failed");

`else

`define QPAM_ASSERT(lbl, clk, rst_n, prop)
`define QPAM_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> hdl/qpam_pkg.sv
package qpam_pkg;

    // coordinate width of points and results
    localparam int COORD_WIDTH = 32;
    // matrix entries and vertex halves are signed Q16.16 words
    localparam int ENT_W       = 32;
    localparam int PROD_W      = ENT_W + COORD_WIDTH;
    localparam int RND_W       = PROD_W - 16;
    localparam int SUM_W       = RND_W + 2;
    localparam int DET_PW      = 2 * ENT_W;
    localparam int DET_RW      = DET_PW - 16;
    localparam int WGT_W       = 32;
    localparam int WPROD_W     = 2 * WGT_W;

    // pipeline depth from input register to output register
    localparam int STAGES      = 7;

    // register file
    localparam int NUM_VTX     = 6;
    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 6;
    localparam int REG_IDX_W   = 3;
    localparam int MODE_W      = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_VERTEX_0   = 3'd0,
        REG_VERTEX_1   = 3'd1,
        REG_VERTEX_2   = 3'd2,
        REG_VERTEX_3   = 3'd3,
        REG_VERTEX_4   = 3'd4,
        REG_VERTEX_5   = 3'd5,
        REG_SHARED_DIM = 3'd6
    } t_reg_idx;

    // shared dimension codes
    localparam logic [MODE_W-1:0] MODE_NONE   = 3'b111;
    localparam logic [MODE_W-1:0] MODE_VERTEX = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EDGE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FULL   = 3'd2;

    typedef struct packed {
        logic [NUM_VTX-1:0][DATA_W-1:0] vtx;
        logic [MODE_W-1:0]              mode;
    } t_cfg;

    // saturated difference of two vertex halves
    function automatic logic signed [ENT_W-1:0] vdiff(
        input logic signed [ENT_W-1:0] a,
        input logic signed [ENT_W-1:0] b
    );
        logic signed [ENT_W:0] d;
        d = {a[ENT_W-1], a} - {b[ENT_W-1], b};
        if (d[ENT_W] != d[ENT_W-1]) begin
            vdiff = d[ENT_W] ? {1'b1, {(ENT_W-1){1'b0}}} : {1'b0, {(ENT_W-1){1'b1}}};
        end else begin
            vdiff = d[ENT_W-1:0];
        end
    endfunction

    // entry times coordinate, full width
    function automatic logic signed [PROD_W-1:0] mul_c(
        input logic signed [ENT_W-1:0]       a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        mul_c = PROD_W'(a) * PROD_W'(b);
    endfunction

    // entry times entry, full width
    function automatic logic signed [DET_PW-1:0] mul_d(
        input logic signed [ENT_W-1:0] a,
        input logic signed [ENT_W-1:0] b
    );
        mul_d = DET_PW'(a) * DET_PW'(b);
    endfunction

    // round half up to Q16.16
    function automatic logic signed [RND_W-1:0] qround_c(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(32768);
        qround_c = t[PROD_W-1:16];
    endfunction

    function automatic logic signed [DET_RW-1:0] qround_d(input logic signed [DET_PW-1:0] p);
        logic signed [DET_PW-1:0] t;
        t = p + DET_PW'(32768);
        qround_d = t[DET_PW-1:16];
    endfunction

    // clamp a sum into the coordinate range
    function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-COORD_WIDTH:0] hi;
        hi = s[SUM_W-1:COORD_WIDTH-1];
        if (hi == '0 || hi == '1) begin
            sat_coord = s[COORD_WIDTH-1:0];
        end else if (s[SUM_W-1]) begin
            sat_coord = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            sat_coord = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    // magnitude of a determinant, clamped to unsigned 32 bits
    function automatic logic [WGT_W-1:0] abs_det(
        input logic signed [DET_RW-1:0] ra,
        input logic signed [DET_RW-1:0] rb
    );
        logic signed [DET_RW:0] d;
        logic        [DET_RW:0] mag;
        d   = {ra[DET_RW-1], ra} - {rb[DET_RW-1], rb};
        mag = d[DET_RW] ? (~d + 1'b1) : d;
        if (mag[DET_RW:WGT_W] != '0) begin
            abs_det = '1;
        end else begin
            abs_det = mag[WGT_W-1:0];
        end
    endfunction

    // round an unsigned weight product and clamp to 32 bits
    function automatic logic [WGT_W-1:0] wround(input logic [WPROD_W-1:0] p);
        logic [WPROD_W:0]    t;
        logic [WPROD_W-16:0] s;
        t = {1'b0, p} + (WPROD_W+1)'(32768);
        s = t[WPROD_W:16];
        if (s[WPROD_W-16:WGT_W] != '0) begin
            wround = '1;
        end else begin
            wround = s[WGT_W-1:0];
        end
    endfunction

endpackage

>>> hdl/qpam_datapath.sv
`include "quadrature_point_affine_map_top_macros.svh"

module qpam_datapath (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  qpam_pkg::t_cfg                            i_cfg,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic signed [qpam_pkg::COORD_WIDTH-1:0]   i_ref_u_x,
    input  logic signed [qpam_pkg::COORD_WIDTH-1:0]   i_ref_u_y,
    input  logic signed [qpam_pkg::COORD_WIDTH-1:0]   i_ref_v_x,
    input  logic signed [qpam_pkg::COORD_WIDTH-1:0]   i_ref_v_y,
    input  logic signed [qpam_pkg::COORD_WIDTH-1:0]   i_extra_a,
    input  logic signed [qpam_pkg::COORD_WIDTH-1:0]   i_extra_b,
    input  logic        [qpam_pkg::WGT_W-1:0]         i_weight_in,
    input  logic                                      i_last_in,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic signed [qpam_pkg::COORD_WIDTH-1:0]   o_phys_x_x,
    output logic signed [qpam_pkg::COORD_WIDTH-1:0]   o_phys_x_y,
    output logic signed [qpam_pkg::COORD_WIDTH-1:0]   o_phys_y_x,
    output logic signed [qpam_pkg::COORD_WIDTH-1:0]   o_phys_y_y,
    output logic signed [qpam_pkg::COORD_WIDTH-1:0]   o_extra_a_out,
    output logic signed [qpam_pkg::COORD_WIDTH-1:0]   o_extra_b_out,
    output logic        [qpam_pkg::WGT_W-1:0]         o_weight_out,
    output logic                                      o_last_out
);

    // mapped point carried from the sum stage to the output
    typedef struct packed {
        logic [qpam_pkg::COORD_WIDTH-1:0] px_x;
        logic [qpam_pkg::COORD_WIDTH-1:0] px_y;
        logic [qpam_pkg::COORD_WIDTH-1:0] py_x;
        logic [qpam_pkg::COORD_WIDTH-1:0] py_y;
        logic [qpam_pkg::COORD_WIDTH-1:0] ea;
        logic [qpam_pkg::COORD_WIDTH-1:0] eb;
        logic                             last;
    } t_pt;

    // stage valid bits and advance enables
    logic [qpam_pkg::STAGES:1] r_v;
    logic [qpam_pkg::STAGES:1] en;

    // stage 1: matrices from the vertex registers, inputs captured
    logic signed [qpam_pkg::ENT_W-1:0]       r_s1_a1 [4];
    logic signed [qpam_pkg::ENT_W-1:0]       r_s1_a2 [4];
    logic signed [qpam_pkg::ENT_W-1:0]       r_s1_o1x, r_s1_o1y, r_s1_o2x, r_s1_o2y;
    logic signed [qpam_pkg::COORD_WIDTH-1:0] r_s1_ux, r_s1_uy, r_s1_vx, r_s1_vy;
    logic signed [qpam_pkg::COORD_WIDTH-1:0] r_s1_ea, r_s1_eb;
    logic        [qpam_pkg::WGT_W-1:0]       r_s1_w;
    logic                                    r_s1_last;
    logic        [qpam_pkg::MODE_W-1:0]      r_s1_mode;

    logic signed [qpam_pkg::ENT_W-1:0]       n_a1 [4];
    logic signed [qpam_pkg::ENT_W-1:0]       n_a2 [4];
    logic        [qpam_pkg::DATA_W-1:0]      n_q0, n_q1, n_q2;

    // stage 2: raw products
    logic signed [qpam_pkg::PROD_W-1:0]      r_s2_prod  [12];
    logic signed [qpam_pkg::DET_PW-1:0]      r_s2_dprod [4];
    logic signed [qpam_pkg::ENT_W-1:0]       r_s2_o1x, r_s2_o1y, r_s2_o2x, r_s2_o2y;
    logic signed [qpam_pkg::COORD_WIDTH-1:0] r_s2_ea, r_s2_eb;
    logic        [qpam_pkg::WGT_W-1:0]       r_s2_w;
    logic                                    r_s2_last;
    logic        [qpam_pkg::MODE_W-1:0]      r_s2_mode;

    // stage 3: rounded sums, extra pair, determinants
    logic signed [qpam_pkg::RND_W-1:0]       n_rnd [12];
    logic signed [qpam_pkg::DET_RW-1:0]      n_rdet [4];
    t_pt                                     n_s3_pt;
    logic        [qpam_pkg::WGT_W-1:0]       n_s3_det1, n_s3_det2;
    t_pt                                     r_s3_pt;
    logic        [qpam_pkg::WGT_W-1:0]       r_s3_det1, r_s3_det2, r_s3_w;

    // stages 4 to 7: weight scaled by both determinants
    t_pt                                     r_s4_pt, r_s5_pt, r_s6_pt, r_s7_pt;
    logic        [qpam_pkg::WPROD_W-1:0]     r_s4_wp, r_s6_wp;
    logic        [qpam_pkg::WGT_W-1:0]       r_s4_det2, r_s5_det2;
    logic        [qpam_pkg::WGT_W-1:0]       r_s5_w, r_s7_w;

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        en[qpam_pkg::STAGES] = !r_v[qpam_pkg::STAGES] || !i_stall;
        for (int k = qpam_pkg::STAGES - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[1];
    assign o_valid = r_v[qpam_pkg::STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= qpam_pkg::STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // second map corners chosen by the shared dimension
    always_comb begin
        case (i_cfg.mode)
            qpam_pkg::MODE_VERTEX: begin
                n_q0 = i_cfg.vtx[0];
                n_q1 = i_cfg.vtx[3];
                n_q2 = i_cfg.vtx[4];
            end
            qpam_pkg::MODE_EDGE: begin
                n_q0 = i_cfg.vtx[0];
                n_q1 = i_cfg.vtx[1];
                n_q2 = i_cfg.vtx[3];
            end
            qpam_pkg::MODE_FULL: begin
                n_q0 = i_cfg.vtx[0];
                n_q1 = i_cfg.vtx[1];
                n_q2 = i_cfg.vtx[2];
            end
            default: begin
                n_q0 = i_cfg.vtx[3];
                n_q1 = i_cfg.vtx[4];
                n_q2 = i_cfg.vtx[5];
            end
        endcase

        n_a1[0] = qpam_pkg::vdiff(i_cfg.vtx[1][63:32], i_cfg.vtx[0][63:32]);
        n_a1[1] = qpam_pkg::vdiff(i_cfg.vtx[2][63:32], i_cfg.vtx[0][63:32]);
        n_a1[2] = qpam_pkg::vdiff(i_cfg.vtx[1][31:0],  i_cfg.vtx[0][31:0]);
        n_a1[3] = qpam_pkg::vdiff(i_cfg.vtx[2][31:0],  i_cfg.vtx[0][31:0]);

        n_a2[0] = qpam_pkg::vdiff(n_q1[63:32], n_q0[63:32]);
        n_a2[1] = qpam_pkg::vdiff(n_q2[63:32], n_q0[63:32]);
        n_a2[2] = qpam_pkg::vdiff(n_q1[31:0],  n_q0[31:0]);
        n_a2[3] = qpam_pkg::vdiff(n_q2[31:0],  n_q0[31:0]);
    end

    // rounding, sums and extra-pair rule
    always_comb begin
        for (int k = 0; k < 12; k++) begin
            n_rnd[k] = qpam_pkg::qround_c(r_s2_prod[k]);
        end
        for (int k = 0; k < 4; k++) begin
            n_rdet[k] = qpam_pkg::qround_d(r_s2_dprod[k]);
        end

        n_s3_pt.px_x = qpam_pkg::sat_coord(qpam_pkg::SUM_W'(n_rnd[0])
            + qpam_pkg::SUM_W'(n_rnd[1]) + qpam_pkg::SUM_W'(r_s2_o1x));
        n_s3_pt.px_y = qpam_pkg::sat_coord(qpam_pkg::SUM_W'(n_rnd[2])
            + qpam_pkg::SUM_W'(n_rnd[3]) + qpam_pkg::SUM_W'(r_s2_o1y));
        n_s3_pt.py_x = qpam_pkg::sat_coord(qpam_pkg::SUM_W'(n_rnd[4])
            + qpam_pkg::SUM_W'(n_rnd[5]) + qpam_pkg::SUM_W'(r_s2_o2x));
        n_s3_pt.py_y = qpam_pkg::sat_coord(qpam_pkg::SUM_W'(n_rnd[6])
            + qpam_pkg::SUM_W'(n_rnd[7]) + qpam_pkg::SUM_W'(r_s2_o2y));

        case (r_s2_mode)
            qpam_pkg::MODE_FULL: begin
                n_s3_pt.ea = qpam_pkg::sat_coord(qpam_pkg::SUM_W'(n_rnd[8])
                    + qpam_pkg::SUM_W'(n_rnd[9]));
                n_s3_pt.eb = qpam_pkg::sat_coord(qpam_pkg::SUM_W'(n_rnd[10])
                    + qpam_pkg::SUM_W'(n_rnd[11]));
            end
            qpam_pkg::MODE_EDGE: begin
                // a*A1[0][0] + v_y*A2[0][1] - u_y*A1[0][1]
                n_s3_pt.ea = qpam_pkg::sat_coord(qpam_pkg::SUM_W'(n_rnd[8])
                    + qpam_pkg::SUM_W'(n_rnd[5]) - qpam_pkg::SUM_W'(n_rnd[1]));
                n_s3_pt.eb = r_s2_eb;
            end
            default: begin
                n_s3_pt.ea = r_s2_ea;
                n_s3_pt.eb = r_s2_eb;
            end
        endcase
        n_s3_pt.last = r_s2_last;

        n_s3_det1 = qpam_pkg::abs_det(n_rdet[0], n_rdet[1]);
        n_s3_det2 = qpam_pkg::abs_det(n_rdet[2], n_rdet[3]);
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        // stage 1
        if (en[1]) begin
            r_s1_a1   <= n_a1;
            r_s1_a2   <= n_a2;
            r_s1_o1x  <= i_cfg.vtx[0][63:32];
            r_s1_o1y  <= i_cfg.vtx[0][31:0];
            r_s1_o2x  <= n_q0[63:32];
            r_s1_o2y  <= n_q0[31:0];
            r_s1_ux   <= i_ref_u_x;
            r_s1_uy   <= i_ref_u_y;
            r_s1_vx   <= i_ref_v_x;
            r_s1_vy   <= i_ref_v_y;
            r_s1_ea   <= i_extra_a;
            r_s1_eb   <= i_extra_b;
            r_s1_w    <= i_weight_in;
            r_s1_last <= i_last_in;
            r_s1_mode <= i_cfg.mode;
        end
        // stage 2
        if (en[2]) begin
            r_s2_prod[0]  <= qpam_pkg::mul_c(r_s1_a1[0], r_s1_ux);
            r_s2_prod[1]  <= qpam_pkg::mul_c(r_s1_a1[1], r_s1_uy);
            r_s2_prod[2]  <= qpam_pkg::mul_c(r_s1_a1[2], r_s1_ux);
            r_s2_prod[3]  <= qpam_pkg::mul_c(r_s1_a1[3], r_s1_uy);
            r_s2_prod[4]  <= qpam_pkg::mul_c(r_s1_a2[0], r_s1_vx);
            r_s2_prod[5]  <= qpam_pkg::mul_c(r_s1_a2[1], r_s1_vy);
            r_s2_prod[6]  <= qpam_pkg::mul_c(r_s1_a2[2], r_s1_vx);
            r_s2_prod[7]  <= qpam_pkg::mul_c(r_s1_a2[3], r_s1_vy);
            r_s2_prod[8]  <= qpam_pkg::mul_c(r_s1_a1[0], r_s1_ea);
            r_s2_prod[9]  <= qpam_pkg::mul_c(r_s1_a1[1], r_s1_eb);
            r_s2_prod[10] <= qpam_pkg::mul_c(r_s1_a1[2], r_s1_ea);
            r_s2_prod[11] <= qpam_pkg::mul_c(r_s1_a1[3], r_s1_eb);
            r_s2_dprod[0] <= qpam_pkg::mul_d(r_s1_a1[3], r_s1_a1[0]);
            r_s2_dprod[1] <= qpam_pkg::mul_d(r_s1_a1[2], r_s1_a1[1]);
            r_s2_dprod[2] <= qpam_pkg::mul_d(r_s1_a2[3], r_s1_a2[0]);
            r_s2_dprod[3] <= qpam_pkg::mul_d(r_s1_a2[2], r_s1_a2[1]);
            r_s2_o1x      <= r_s1_o1x;
            r_s2_o1y      <= r_s1_o1y;
            r_s2_o2x      <= r_s1_o2x;
            r_s2_o2y      <= r_s1_o2y;
            r_s2_ea       <= r_s1_ea;
            r_s2_eb       <= r_s1_eb;
            r_s2_w        <= r_s1_w;
            r_s2_last     <= r_s1_last;
            r_s2_mode     <= r_s1_mode;
        end
        // stage 3
        if (en[3]) begin
            r_s3_pt   <= n_s3_pt;
            r_s3_det1 <= n_s3_det1;
            r_s3_det2 <= n_s3_det2;
            r_s3_w    <= r_s2_w;
        end
        // stage 4: weight times first determinant
        if (en[4]) begin
            r_s4_pt   <= r_s3_pt;
            r_s4_wp   <= qpam_pkg::WPROD_W'(r_s3_w) * qpam_pkg::WPROD_W'(r_s3_det1);
            r_s4_det2 <= r_s3_det2;
        end
        // stage 5
        if (en[5]) begin
            r_s5_pt   <= r_s4_pt;
            r_s5_w    <= qpam_pkg::wround(r_s4_wp);
            r_s5_det2 <= r_s4_det2;
        end
        // stage 6: times second determinant
        if (en[6]) begin
            r_s6_pt <= r_s5_pt;
            r_s6_wp <= qpam_pkg::WPROD_W'(r_s5_w) * qpam_pkg::WPROD_W'(r_s5_det2);
        end
        // stage 7: output register
        if (en[7]) begin
            r_s7_pt <= r_s6_pt;
            r_s7_w  <= qpam_pkg::wround(r_s6_wp);
        end
    end

    assign o_phys_x_x    = r_s7_pt.px_x;
    assign o_phys_x_y    = r_s7_pt.px_y;
    assign o_phys_y_x    = r_s7_pt.py_x;
    assign o_phys_y_y    = r_s7_pt.py_y;
    assign o_extra_a_out = r_s7_pt.ea;
    assign o_extra_b_out = r_s7_pt.eb;
    assign o_weight_out  = r_s7_w;
    assign o_last_out    = r_s7_pt.last;

    // the input backs up only when the first stage holds a request
    `QPAM_ASSERT(a_stall_needs_s1, i_clk, i_rst_n, o_stall |-> r_v[1])
    // an empty output stage never backs up the input
    `QPAM_ASSERT(a_empty_out_no_stall, i_clk, i_rst_n, !r_v[qpam_pkg::STAGES] |-> !o_stall)
    // requests in flight change only by accepts in and out
    `QPAM_ASSERT(a_count, i_clk, i_rst_n, $past(i_rst_n) |-> ($countones(r_v) == $countones($past(r_v)) + int'($past(i_valid && !o_stall)) - int'($past(o_valid && !i_stall))))
    // reset empties the pipeline
    `QPAM_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (r_v == '0))

endmodule

>>> hdl/quadrature_point_affine_map_top.sv
// channel  direction  handshake          payload
// points   in         i_valid / o_stall  i_ref_u_*, i_ref_v_*, i_extra_*, i_weight_in, i_last_in
// results  out        o_valid / i_stall  o_phys_*, o_extra_*_out, o_weight_out, o_last_out
// config   in         apb psel/penable   paddr = 8 * register index, 64-bit data
//
// one point per cycle while o_stall is low; each taken request passes in order
// through 7 register stages, the first loading at the accepting edge: vertex
// difference, product, sum, then two weight multiplies each followed by a rounding stage
// reset is synchronous and empties the pipeline; vertices reset to 0, dimension to -1
// a stall holds the output register; empty stages behind it keep filling,
// and o_stall rises once the request in the first stage cannot move

module quadrature_point_affine_map_top (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // point requests
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic signed [qpam_pkg::COORD_WIDTH-1:0]   i_ref_u_x,
    input  logic signed [qpam_pkg::COORD_WIDTH-1:0]   i_ref_u_y,
    input  logic signed [qpam_pkg::COORD_WIDTH-1:0]   i_ref_v_x,
    input  logic signed [qpam_pkg::COORD_WIDTH-1:0]   i_ref_v_y,
    input  logic signed [qpam_pkg::COORD_WIDTH-1:0]   i_extra_a,
    input  logic signed [qpam_pkg::COORD_WIDTH-1:0]   i_extra_b,
    input  logic        [qpam_pkg::WGT_W-1:0]         i_weight_in,
    input  logic                                      i_last_in,
    // mapped results
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic signed [qpam_pkg::COORD_WIDTH-1:0]   o_phys_x_x,
    output logic signed [qpam_pkg::COORD_WIDTH-1:0]   o_phys_x_y,
    output logic signed [qpam_pkg::COORD_WIDTH-1:0]   o_phys_y_x,
    output logic signed [qpam_pkg::COORD_WIDTH-1:0]   o_phys_y_y,
    output logic signed [qpam_pkg::COORD_WIDTH-1:0]   o_extra_a_out,
    output logic signed [qpam_pkg::COORD_WIDTH-1:0]   o_extra_b_out,
    output logic        [qpam_pkg::WGT_W-1:0]         o_weight_out,
    output logic                                      o_last_out,
    // register port
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic        [qpam_pkg::ADDR_W-1:0]        paddr,
    input  logic        [qpam_pkg::DATA_W-1:0]        pwdata,
    output logic        [qpam_pkg::DATA_W-1:0]        prdata,
    output logic                                      pready
);

    logic [qpam_pkg::NUM_VTX-1:0][qpam_pkg::DATA_W-1:0] r_vtx;
    logic [qpam_pkg::MODE_W-1:0]                        r_mode;
    qpam_pkg::t_cfg                                     cfg;
    qpam_pkg::t_reg_idx                                 reg_idx;
    logic                                               wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = qpam_pkg::t_reg_idx'(paddr[qpam_pkg::ADDR_W-1:qpam_pkg::ADDR_W-3]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx  <= '0;
            r_mode <= qpam_pkg::MODE_NONE;
        end else if (wr_en) begin
            case (reg_idx)
                qpam_pkg::REG_VERTEX_0:   r_vtx[0] <= pwdata;
                qpam_pkg::REG_VERTEX_1:   r_vtx[1] <= pwdata;
                qpam_pkg::REG_VERTEX_2:   r_vtx[2] <= pwdata;
                qpam_pkg::REG_VERTEX_3:   r_vtx[3] <= pwdata;
                qpam_pkg::REG_VERTEX_4:   r_vtx[4] <= pwdata;
                qpam_pkg::REG_VERTEX_5:   r_vtx[5] <= pwdata;
                qpam_pkg::REG_SHARED_DIM: r_mode   <= pwdata[qpam_pkg::MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register reads, dimension sign extended
    always_comb begin
        case (reg_idx)
            qpam_pkg::REG_VERTEX_0:   prdata = r_vtx[0];
            qpam_pkg::REG_VERTEX_1:   prdata = r_vtx[1];
            qpam_pkg::REG_VERTEX_2:   prdata = r_vtx[2];
            qpam_pkg::REG_VERTEX_3:   prdata = r_vtx[3];
            qpam_pkg::REG_VERTEX_4:   prdata = r_vtx[4];
            qpam_pkg::REG_VERTEX_5:   prdata = r_vtx[5];
            qpam_pkg::REG_SHARED_DIM:
                prdata = {{(qpam_pkg::DATA_W-qpam_pkg::MODE_W){r_mode[qpam_pkg::MODE_W-1]}},
                          r_mode};
            default:                  prdata = '0;
        endcase
    end

    assign cfg.vtx  = r_vtx;
    assign cfg.mode = r_mode;

    // mapping pipeline
    qpam_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ref_u_x     (i_ref_u_x),
        .i_ref_u_y     (i_ref_u_y),
        .i_ref_v_x     (i_ref_v_x),
        .i_ref_v_y     (i_ref_v_y),
        .i_extra_a     (i_extra_a),
        .i_extra_b     (i_extra_b),
        .i_weight_in   (i_weight_in),
        .i_last_in     (i_last_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_phys_x_x    (o_phys_x_x),
        .o_phys_x_y    (o_phys_x_y),
        .o_phys_y_x    (o_phys_y_x),
        .o_phys_y_y    (o_phys_y_y),
        .o_extra_a_out (o_extra_a_out),
        .o_extra_b_out (o_extra_b_out),
        .o_weight_out  (o_weight_out),
        .o_last_out    (o_last_out)
    );

endmodule
